// ===== hw/rtl/liquid_slosh_modal_rk4_macros.svh =====
// Assertion helpers used by the top-level RTL module.
`ifndef LIQUID_SLOSH_MODAL_RK4_MACROS_SVH
`define LIQUID_SLOSH_MODAL_RK4_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define LSM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define LSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lsm_pkg.sv =====
package lsm_pkg;

  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY_STIFFNESS    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY_DAMPING_TERM = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_STIFFNESS     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_DAMPING_TERM  = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LONGITUDINAL_GAIN    = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LATERAL_GAIN         = 8'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY_HEIGHT_GAIN  = 8'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HEIGHT_GAIN   = 8'd7;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_FORCE,
    OP_DAMP,
    OP_STIFF,
    OP_ACC,
    OP_EPT,
    OP_VPT,
    OP_EFIN,
    OP_EDIV,
    OP_VFIN,
    OP_VDIV,
    OP_SQX,
    OP_SQY,
    OP_SQRT,
    OP_HGT,
    OP_FIN
  } op_e;

  typedef struct packed {
    logic [31:0] primary_stiffness;
    logic [31:0] primary_damping_term;
    logic [31:0] second_stiffness;
    logic [31:0] second_damping_term;
    logic [31:0] longitudinal_gain;
    logic [31:0] lateral_gain;
    logic [31:0] primary_height_gain;
    logic [31:0] second_height_gain;
  } cfg_t;

  typedef struct packed {
    op_e        op;
    logic [1:0] axis;
    logic [1:0] stage;
    logic       mode;
    logic       accept;
    logic       issue;
    logic       wb;
    logic       sq_start;
  } cmd_t;

  typedef struct packed {
    logic out_full;
    logic sq_busy;
  } sts_t;

endpackage

// ===== hw/rtl/lsm_sqrt.sv =====
module lsm_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        busy_o,
  output logic [31:0] root_o
);

  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [63:0] val_q, val_d;
  logic [35:0] rem_sh, trial, diff;
  logic        ge;

  always_comb begin
    rem_sh = {rem_q, val_q[63:62]};
    trial  = {2'b00, root_q, 2'b01};
    diff   = rem_sh - trial;
    ge     = rem_sh >= trial;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    root_d = root_q;
    val_d  = val_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      root_d = '0;
      val_d  = radicand_i;
    end else if (busy_q) begin
      rem_d  = ge ? diff[33:0] : rem_sh[33:0];
      root_d = {root_q[30:0], ge};
      val_d  = {val_q[61:0], 2'b00};
      cnt_d  = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    val_q  <= val_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

// ===== hw/rtl/lsm_dp.sv =====
module lsm_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lsm_pkg::cfg_t       cfg_i,
  input  lsm_pkg::cmd_t       cmd_i,
  output lsm_pkg::sts_t       sts_o,
  input  logic signed [31:0]  long_accel_i,
  input  logic signed [31:0]  lat_accel_i,
  input  logic [25:0]         step_time_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [30:0]         slosh_height_o,
  output logic signed [31:0]  primary_long_disp_o,
  output logic signed [31:0]  primary_lat_disp_o,
  output logic                saturated_o
);
  import lsm_pkg::*;

  localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;
  localparam logic [70:0] HALF15 = 71'd1 << 15;
  localparam logic [70:0] HALF19 = 71'd1 << 19;
  localparam logic [70:0] HALF27 = 71'd1 << 27;
  localparam logic [70:0] HALF31 = 71'd1 << 31;
  localparam logic [70:0] HALF32 = 71'd1 << 32;
  localparam logic [70:0] BIAS6  = 71'd3 << 32;
  localparam logic signed [49:0] S_MAX = 50'sd2147483647;
  localparam logic signed [49:0] S_MIN = -(50'sd2147483648);
  localparam logic signed [49:0] D_MAX = 50'sd34359738367;
  localparam logic signed [49:0] D_MIN = -(50'sd34359738368);
  localparam logic [37:0] H_MAX = 38'h7FFFFFFF;

  function automatic logic [38:0] abs39(input logic signed [38:0] x);
    return x[38] ? 39'(-x) : 39'(x);
  endfunction

  function automatic logic signed [49:0] sgn(input logic [49:0] m, input logic neg);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [49:0] clip(input logic signed [49:0] x,
                                              input logic signed [49:0] lo,
                                              input logic signed [49:0] hi);
    logic signed [49:0] r;
    r = x;
    if (x > hi) r = hi;
    if (x < lo) r = lo;
    return r;
  endfunction

  logic signed [31:0] disp_q [4];
  logic signed [31:0] vel_q [4];
  logic signed [31:0] acc_l_q, acc_t_q;
  logic [25:0]        dt_q;
  logic signed [31:0] e0_q, v0_q, e_q, v_q;
  logic signed [43:0] force_q;
  logic signed [49:0] dacc_q;
  logic signed [35:0] dv_q;
  logic signed [34:0] se_q;
  logic signed [38:0] sv_q;
  logic [31:0]        y_q;
  logic [69:0]        prod_q;
  logic [63:0]        sumsq_q;
  logic [37:0]        h_q;
  logic               sat_q;
  logic               out_valid_q;
  logic [30:0]        out_h_q;
  logic signed [31:0] out_el_q, out_et_q;
  logic               out_sat_q;

  logic               prim, lon, w2, sq_busy;
  logic [31:0]        kk, cc, gg, hg, root, mul_a;
  logic [37:0]        mul_b;
  logic signed [31:0] acc, hx, hy;
  logic [38:0]        mag_acc, mag_v, mag_e, mag_dv, mag_se, mag_sv, mag_hx, mag_hy;
  logic [69:0]        prod_d;
  logic [70:0]        p71, r16, r20, r28, r32, r33, ybias;
  logic [49:0]        rsel;
  logic signed [49:0] damp_t, stiff_t, deriv, deriv_c, sum, sum_c;
  logic               deriv_ovf, sum_ovf, h_ovf;

  always_comb begin
    prim    = !cmd_i.axis[1];
    lon     = !cmd_i.axis[0];
    kk      = prim ? cfg_i.primary_stiffness : cfg_i.second_stiffness;
    cc      = prim ? cfg_i.primary_damping_term : cfg_i.second_damping_term;
    gg      = lon ? cfg_i.longitudinal_gain : cfg_i.lateral_gain;
    hg      = cmd_i.mode ? cfg_i.second_height_gain : cfg_i.primary_height_gain;
    acc     = lon ? acc_l_q : acc_t_q;
    hx      = disp_q[{cmd_i.mode, 1'b0}];
    hy      = disp_q[{cmd_i.mode, 1'b1}];
    mag_acc = abs39(39'(acc));
    mag_v   = abs39(39'(v_q));
    mag_e   = abs39(39'(e_q));
    mag_dv  = abs39(39'(dv_q));
    mag_se  = abs39(39'(se_q));
    mag_sv  = abs39(sv_q);
    mag_hx  = abs39(39'(hx));
    mag_hy  = abs39(39'(hy));
    case (cmd_i.op)
      OP_FORCE: begin mul_a = gg;             mul_b = mag_acc[37:0]; end
      OP_DAMP:  begin mul_a = cc;             mul_b = mag_v[37:0]; end
      OP_STIFF: begin mul_a = kk;             mul_b = mag_e[37:0]; end
      OP_EPT:   begin mul_a = 32'(dt_q);      mul_b = mag_v[37:0]; end
      OP_VPT:   begin mul_a = 32'(dt_q);      mul_b = mag_dv[37:0]; end
      OP_EFIN:  begin mul_a = 32'(dt_q);      mul_b = mag_se[37:0]; end
      OP_VFIN:  begin mul_a = 32'(dt_q);      mul_b = mag_sv[37:0]; end
      OP_EDIV:  begin mul_a = RECIP3;         mul_b = 38'(y_q); end
      OP_VDIV:  begin mul_a = RECIP3;         mul_b = 38'(y_q); end
      OP_SQX:   begin mul_a = mag_hx[31:0];   mul_b = 38'(mag_hx[31:0]); end
      OP_SQY:   begin mul_a = mag_hy[31:0];   mul_b = 38'(mag_hy[31:0]); end
      OP_HGT:   begin mul_a = hg;             mul_b = 38'(root); end
      default:  begin mul_a = '0;             mul_b = '0; end
    endcase
    prod_d = {38'b0, mul_a} * {32'b0, mul_b};

    p71     = {1'b0, prod_q};
    r16     = (p71 + HALF15) >> 16;
    r20     = (p71 + HALF19) >> 20;
    r28     = (p71 + HALF27) >> 28;
    r32     = (p71 + HALF31) >> 32;
    r33     = (p71 + HALF32) >> 33;
    ybias   = (p71 + BIAS6) >> 33;
    damp_t  = sgn(r16[49:0], v_q[31]);
    stiff_t = sgn(r16[49:0], e_q[31]);
    deriv   = dacc_q - stiff_t - 50'(force_q);
    deriv_c = clip(deriv, D_MIN, D_MAX);
    deriv_ovf = (deriv > D_MAX) || (deriv < D_MIN);
    rsel    = (cmd_i.stage == 2'd2) ? r32[49:0] : r33[49:0];
    w2      = (cmd_i.stage == 2'd1) || (cmd_i.stage == 2'd2);
    case (cmd_i.op)
      OP_EPT:  sum = 50'(e0_q) + sgn(rsel, v_q[31]);
      OP_VPT:  sum = 50'(v0_q) + sgn(rsel, dv_q[35]);
      OP_EDIV: sum = 50'(e0_q) + sgn(50'(prod_q >> 33), se_q[34]);
      OP_VDIV: sum = 50'(v0_q) + sgn(50'(prod_q >> 33), sv_q[38]);
      default: sum = '0;
    endcase
    sum_c   = clip(sum, S_MIN, S_MAX);
    sum_ovf = (sum > S_MAX) || (sum < S_MIN);
    h_ovf   = h_q > H_MAX;
  end

  lsm_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sq_start),
    .radicand_i (sumsq_q),
    .busy_o     (sq_busy),
    .root_o     (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        disp_q[i] <= '0;
        vel_q[i]  <= '0;
      end
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.accept) begin
        sat_q <= 1'b0;
      end
      if (cmd_i.wb) begin
        case (cmd_i.op)
          OP_STIFF: begin
            if (deriv_ovf) sat_q <= 1'b1;
          end
          OP_EPT, OP_VPT: begin
            if (sum_ovf) sat_q <= 1'b1;
          end
          OP_EDIV: begin
            disp_q[cmd_i.axis] <= 32'(sum_c);
            if (sum_ovf) sat_q <= 1'b1;
          end
          OP_VDIV: begin
            vel_q[cmd_i.axis] <= 32'(sum_c);
            if (sum_ovf) sat_q <= 1'b1;
          end
          OP_FIN: begin
            out_valid_q <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      acc_l_q <= long_accel_i;
      acc_t_q <= lat_accel_i;
      dt_q    <= step_time_i;
      h_q     <= '0;
    end
    if (cmd_i.issue) begin
      prod_q <= prod_d;
    end
    if (cmd_i.wb) begin
      case (cmd_i.op)
        OP_LOAD: begin
          e0_q <= disp_q[cmd_i.axis];
          v0_q <= vel_q[cmd_i.axis];
          e_q  <= disp_q[cmd_i.axis];
          v_q  <= vel_q[cmd_i.axis];
          se_q <= '0;
          sv_q <= '0;
        end
        OP_FORCE: force_q <= 44'(sgn(r20[49:0], acc[31]));
        OP_DAMP:  dacc_q  <= -damp_t;
        OP_STIFF: dv_q    <= 36'(deriv_c);
        OP_ACC: begin
          se_q <= se_q + (w2 ? (35'(v_q) <<< 1) : 35'(v_q));
          sv_q <= sv_q + (w2 ? (39'(dv_q) <<< 1) : 39'(dv_q));
        end
        OP_EPT:  e_q <= 32'(sum_c);
        OP_VPT:  v_q <= 32'(sum_c);
        OP_EFIN, OP_VFIN: y_q <= ybias[31:0];
        OP_SQX:  sumsq_q <= prod_q[63:0];
        OP_SQY:  sumsq_q <= sumsq_q + prod_q[63:0];
        OP_HGT:  h_q <= h_q + r28[37:0];
        OP_FIN: begin
          out_h_q   <= h_ovf ? H_MAX[30:0] : h_q[30:0];
          out_el_q  <= disp_q[0];
          out_et_q  <= disp_q[1];
          out_sat_q <= sat_q | h_ovf;
        end
        default: begin
        end
      endcase
    end
  end

  assign sts_o.out_full     = out_valid_q;
  assign sts_o.sq_busy      = sq_busy;
  assign out_valid_o        = out_valid_q;
  assign slosh_height_o     = out_h_q;
  assign primary_long_disp_o = out_el_q;
  assign primary_lat_disp_o = out_et_q;
  assign saturated_o        = out_sat_q;

endmodule

// ===== hw/rtl/lsm_ctrl.sv =====
module lsm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output lsm_pkg::cmd_t cmd_o,
  input  lsm_pkg::sts_t sts_i
);
  import lsm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WB    = 2'd2;
  localparam logic [1:0] ST_SQW   = 2'd3;
  localparam logic [4:0] LAST_IDX = 5'd23;

  function automatic op_e axis_op(input logic [4:0] idx);
    op_e r;
    case (idx)
      5'd0:                      r = OP_LOAD;
      5'd1:                      r = OP_FORCE;
      5'd2, 5'd7, 5'd12, 5'd17:  r = OP_DAMP;
      5'd3, 5'd8, 5'd13, 5'd18:  r = OP_STIFF;
      5'd4, 5'd9, 5'd14, 5'd19:  r = OP_ACC;
      5'd5, 5'd10, 5'd15:        r = OP_EPT;
      5'd6, 5'd11, 5'd16:        r = OP_VPT;
      5'd20:                     r = OP_EFIN;
      5'd21:                     r = OP_EDIV;
      5'd22:                     r = OP_VFIN;
      5'd23:                     r = OP_VDIV;
      default:                   r = OP_LOAD;
    endcase
    return r;
  endfunction

  function automatic op_e height_op(input logic [1:0] hidx);
    op_e r;
    case (hidx)
      2'd0:    r = OP_SQX;
      2'd1:    r = OP_SQY;
      2'd2:    r = OP_SQRT;
      default: r = OP_HGT;
    endcase
    return r;
  endfunction

  logic [1:0] state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic [4:0] idx_q, idx_d;
  logic       ht_q, ht_d;
  logic       mode_q, mode_d;
  logic [1:0] hidx_q, hidx_d;
  logic       fin_q, fin_d;
  logic       accept, advance;
  op_e        op;
  logic [1:0] stage;

  always_comb begin
    op = fin_q ? OP_FIN : (ht_q ? height_op(hidx_q) : axis_op(idx_q));
    if (idx_q < 5'd7) begin
      stage = 2'd0;
    end else if (idx_q < 5'd12) begin
      stage = 2'd1;
    end else if (idx_q < 5'd17) begin
      stage = 2'd2;
    end else begin
      stage = 2'd3;
    end

    accept          = (state_q == ST_IDLE) && in_valid_i;
    advance         = 1'b0;
    state_d         = state_q;
    cmd_o.op        = op;
    cmd_o.axis      = axis_q;
    cmd_o.stage     = stage;
    cmd_o.mode      = mode_q;
    cmd_o.accept    = accept;
    cmd_o.issue     = 1'b0;
    cmd_o.wb        = 1'b0;
    cmd_o.sq_start  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (op == OP_SQRT) begin
          cmd_o.sq_start = 1'b1;
          state_d        = ST_SQW;
        end else if (!(op == OP_FIN && sts_i.out_full)) begin
          cmd_o.issue = 1'b1;
          state_d     = ST_WB;
        end
      end
      ST_WB: begin
        cmd_o.wb = 1'b1;
        if (op == OP_FIN) begin
          state_d = ST_IDLE;
        end else begin
          advance = 1'b1;
          state_d = ST_ISSUE;
        end
      end
      ST_SQW: begin
        if (!sts_i.sq_busy) begin
          advance = 1'b1;
          state_d = ST_ISSUE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    axis_d = axis_q;
    idx_d  = idx_q;
    ht_d   = ht_q;
    mode_d = mode_q;
    hidx_d = hidx_q;
    fin_d  = fin_q;
    if (accept) begin
      axis_d = '0;
      idx_d  = '0;
      ht_d   = 1'b0;
      mode_d = 1'b0;
      hidx_d = '0;
      fin_d  = 1'b0;
    end else if (advance) begin
      if (!ht_q) begin
        if (idx_q == LAST_IDX) begin
          idx_d = '0;
          if (axis_q == 2'd3) begin
            ht_d = 1'b1;
          end else begin
            axis_d = axis_q + 2'd1;
          end
        end else begin
          idx_d = idx_q + 5'd1;
        end
      end else if (hidx_q == 2'd3) begin
        hidx_d = '0;
        if (mode_q) begin
          fin_d = 1'b1;
        end else begin
          mode_d = 1'b1;
        end
      end else begin
        hidx_d = hidx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= '0;
      idx_q   <= '0;
      ht_q    <= 1'b0;
      mode_q  <= 1'b0;
      hidx_q  <= '0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      idx_q   <= idx_d;
      ht_q    <= ht_d;
      mode_q  <= mode_d;
      hidx_q  <= hidx_d;
      fin_q   <= fin_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// ===== hw/rtl/liquid_slosh_modal_rk4.sv =====
// The RK4 steps run as 96 micro-operations, most of them on one shared 32x38 multiplier,
// and a one-bit-per-cycle square root operation runs once for each of the two modes.
// Inputs are taken one at a time; the next input is taken once the result
// is loaded into the output register, even while that result still waits.
// Reset clears the mode state, the configuration registers and all control state.
`include "liquid_slosh_modal_rk4_macros.svh"

module liquid_slosh_modal_rk4 (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lsm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [31:0]             long_accel_i,
  input  logic signed [31:0]             lat_accel_i,
  input  logic [25:0]                    step_time_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [30:0]                    slosh_height_o,
  output logic signed [31:0]             primary_long_disp_o,
  output logic signed [31:0]             primary_lat_disp_o,
  output logic                           saturated_o
);
  import lsm_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PRIMARY_STIFFNESS:    cfg_q.primary_stiffness    <= cfg_data_i;
        CFG_PRIMARY_DAMPING_TERM: cfg_q.primary_damping_term <= cfg_data_i;
        CFG_SECOND_STIFFNESS:     cfg_q.second_stiffness     <= cfg_data_i;
        CFG_SECOND_DAMPING_TERM:  cfg_q.second_damping_term  <= cfg_data_i;
        CFG_LONGITUDINAL_GAIN:    cfg_q.longitudinal_gain    <= cfg_data_i;
        CFG_LATERAL_GAIN:         cfg_q.lateral_gain         <= cfg_data_i;
        CFG_PRIMARY_HEIGHT_GAIN:  cfg_q.primary_height_gain  <= cfg_data_i;
        CFG_SECOND_HEIGHT_GAIN:   cfg_q.second_height_gain   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  lsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  lsm_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .long_accel_i        (long_accel_i),
    .lat_accel_i         (lat_accel_i),
    .step_time_i         (step_time_i),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .slosh_height_o      (slosh_height_o),
    .primary_long_disp_o (primary_long_disp_o),
    .primary_lat_disp_o  (primary_lat_disp_o),
    .saturated_o         (saturated_o)
  );

  `LSM_ASSERT_NEXT(a_busy_after_transfer, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input transfer did not start a run")
  `LSM_ASSERT_NOW(a_result_from_run, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result appeared without a run")

endmodule
